// ===== hdl/ntanh_pkg.sv =====
// ----------------------------------------------------------------------------
// ntanh_pkg
// Shared constants, register codes and the tanh table generator.
// ----------------------------------------------------------------------------
package ntanh_pkg;

  localparam int TANH_ENTRIES = 256;
  localparam int ROM_AW       = $clog2(TANH_ENTRIES + 1);
  localparam int MUL_W        = 24 + ROM_AW;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // exp step 8/N in Q30
  localparam longint unsigned EXP_STEP = (64'd8 << 30) / TANH_ENTRIES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOPE  = 8'd0,
    REG_CENTER = 8'd1,
    REG_SCALE  = 8'd2,
    REG_BIAS   = 8'd3
  } cfg_reg_t;

  localparam logic [15:0]        SLOPE_RST  = 16'd498;
  localparam logic signed [15:0] CENTER_RST = 16'sd8192;
  localparam logic [15:0]        SCALE_RST  = 16'd171;
  localparam logic signed [15:0] BIAS_RST   = -16'sd24576;

  typedef logic [15:0] rom_t [0:TANH_ENTRIES];

  // restoring long division, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // R[k] ~ 2^15 * tanh(4k/N), built from exp(-8/N) in Q30 by repeated products
  function automatic rom_t build_tanh_rom();
    rom_t                 r;
    longint unsigned      one;
    longint unsigned      half;
    longint unsigned      h;
    longint unsigned      term;
    longint               sum;
    longint unsigned      base;
    longint unsigned      e;
    longint unsigned      num;
    longint unsigned      den;
    longint unsigned      kk;
    one  = 64'd1 << 30;
    half = 64'd1 << 29;
    h    = EXP_STEP;
    term = one;
    sum  = longint'(one);
    for (int k = 1; k <= 12; k++) begin
      kk   = longint'(k);
      term = udiv64((term * h + half) >> 30, kk);
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    base = (sum > 0) ? longint'(sum) : 64'd0;
    e = one;
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      num  = (one - e) << 15;
      den  = one + e;
      r[k] = 16'(udiv64(num + (den >> 1), den));
      e    = (e * base + half) >> 30;
    end
    return r;
  endfunction

  localparam rom_t TANH_ROM = build_tanh_rom();

endpackage

// ===== hdl/normalized_tanh_shaper_core.sv =====
// Throughput: one sample per cycle while the output is not stalled; the nine
// pipeline stages each advance on their own, so a stalled output only halts
// stages that hold data.
// The tanh table is a registered-read ROM with two read ports (stage 4).
// Reset (rst, synchronous): all stage valid bits clear, config registers take
// their reset values, data stages are not reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
// normalized_tanh_shaper_core
// Scaled, biased tanh transfer curve over Q2.14 audio samples.
// ----------------------------------------------------------------------------
module normalized_tanh_shaper_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 sample_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 sample_out,
  output logic                               clipped,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ntanh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ntanh_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ntanh_pkg::*;

  localparam int NSTAGE = 9;

  // configuration registers
  logic [15:0]        slope;
  logic signed [15:0] center;
  logic [15:0]        scale;
  logic signed [15:0] bias;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope  <= SLOPE_RST;
      center <= CENTER_RST;
      scale  <= SCALE_RST;
      bias   <= BIAS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOPE:  slope  <= cfg_data;
        REG_CENTER: center <= signed'(cfg_data);
        REG_SCALE:  scale  <= cfg_data;
        REG_BIAS:   bias   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: offset from center
  logic signed [16:0] s1_d;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d <= 17'(sample_in) - 17'(center);
    end
  end

  // stage 2: argument in units of 2^-22
  logic signed [33:0] s2_arg;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_arg <= 34'(s1_d * signed'({1'b0, slope}));
    end
  end

  // stage 3: magnitude, segment index and fraction
  logic [32:0]      s3_mag;
  logic [MUL_W-1:0] s3_m;
  logic [ROM_AW-1:0] s3_idx;
  logic [15:0]      s3_frac;
  logic             s3_neg;
  logic             s3_sat;

  always_comb begin
    s3_mag = s2_arg[33] ? 33'(-s2_arg) : s2_arg[32:0];
    s3_m   = {{ROM_AW{1'b0}}, s3_mag[23:0]} * MUL_W'(TANH_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_neg  <= s2_arg[33];
      s3_sat  <= (s3_mag[32:24] != '0);
      s3_idx  <= s3_m[24 +: ROM_AW];
      s3_frac <= s3_m[23:8];
    end
  end

  // stage 4: table read, two ports
  logic [15:0] s4_r0;
  logic [15:0] s4_r1;
  logic [15:0] s4_frac;
  logic        s4_neg;
  logic        s4_sat;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_r0   <= TANH_ROM[s3_idx];
      s4_r1   <= TANH_ROM[s3_sat ? s3_idx : ROM_AW'(s3_idx + 1'b1)];
      s4_frac <= s3_frac;
      s4_neg  <= s3_neg;
      s4_sat  <= s3_sat;
    end
  end

  // stage 5: interpolation products
  logic [32:0] s5_p0;
  logic [32:0] s5_p1;
  logic        s5_neg;
  logic        s5_sat;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_p0  <= 33'(s4_r0 * (17'h10000 - {1'b0, s4_frac}));
      s5_p1  <= 33'(s4_r1 * {1'b0, s4_frac});
      s5_neg <= s4_neg;
      s5_sat <= s4_sat;
    end
  end

  // stage 6: round, saturate to one, apply sign
  logic [33:0]        s6_sum;
  logic [16:0]        s6_tmag;
  logic signed [16:0] s6_t;

  always_comb begin
    s6_sum  = 34'(s5_p0) + 34'(s5_p1) + 34'd32768;
    s6_tmag = s5_sat ? 17'd32768 : s6_sum[32:16];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_t <= s5_neg ? -signed'(s6_tmag) : signed'(s6_tmag);
    end
  end

  // stage 7: remove bias
  logic signed [17:0] s7_diff;
  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_diff <= 18'(s6_t) - 18'(bias);
    end
  end

  // stage 8: output gain, units of 2^-23
  logic signed [34:0] s8_prod;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_prod <= 35'(s7_diff * signed'({1'b0, scale}));
    end
  end

  // stage 9: round half up to Q2.14 and saturate
  logic signed [35:0] s9_q;
  logic signed [26:0] s9_y;

  always_comb begin
    s9_q = 36'(s8_prod) + 36'sd256;
    s9_y = 27'(s9_q >>> 9);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      priority if (s9_y > 27'sd32767) begin
        sample_out <= 16'sh7fff;
        clipped    <= 1'b1;
      end else if (s9_y < -27'sd32768) begin
        sample_out <= 16'sh8000;
        clipped    <= 1'b1;
      end else begin
        sample_out <= s9_y[15:0];
        clipped    <= 1'b0;
      end
    end
  end

  assign out_valid = vld[NSTAGE-1];

endmodule

// ===== hdl/ntanh_checker.sv =====
// ----------------------------------------------------------------------------
// ntanh_checker
// Port-level checks for the tanh shaper, bound to the top level.
// ----------------------------------------------------------------------------
module ntanh_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [15:0]                sample_out,
  input logic                              clipped
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("stalled result changed");

  // a clipped result sits at a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (sample_out == 16'sh7fff || sample_out == 16'sh8000))
    else $error("clipped result not at a limit");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // reset drops any result in flight
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind normalized_tanh_shaper_core ntanh_checker u_ntanh_checker (.*);
